@@ rtl/bcti_pkg.sv @@
// Shared types and constants for the Bezier curve table interpolator.
// No dependencies.
package bcti_pkg;

	localparam logic signed [31:0] Q_ONE   = 32'sd65536;
	localparam logic signed [31:0] Q_THREE = 32'sd196608;

	typedef enum logic [0:0] {
		CMD_BUILD  = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_t;

	localparam logic [1:0] REG_CONTROL_ONE  = 2'd0;
	localparam logic [1:0] REG_CONTROL_TWO  = 2'd1;
	localparam logic [1:0] REG_TABLE_LENGTH = 2'd2;

	// one queued command word between front and back
	typedef struct packed {
		cmd_t               cmd;
		logic signed [31:0] pos;
	} cmd_word_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_B_DIV,
		ST_B_OMT,
		ST_B_M1,
		ST_B_M2,
		ST_B_M3,
		ST_B_M4,
		ST_B_M5,
		ST_B_M6,
		ST_B_M7,
		ST_B_M8,
		ST_B_SUM,
		ST_B_NEXT,
		ST_B_DONE,
		ST_L_SCALE,
		ST_L_RD,
		ST_L_WAIT,
		ST_L_MUL1,
		ST_L_MUL2,
		ST_L_OUT
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -34'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// Q16.16 multiply, round half away from zero, saturating
	function automatic logic signed [31:0] qround(input logic signed [63:0] p);
		logic        neg;
		logic [63:0] m;
		logic [63:0] r;
		neg = p[63];
		m = neg ? (64'd0 - p) : p;
		r = (m + 64'd32768) >> 16;
		if (!neg) return (r > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : r[31:0];
		if (r >= 64'h80000000) return 32'sh80000000;
		return 32'(64'd0 - r);
	endfunction

endpackage

@@ rtl/bezier_curve_table_interpolator.sv @@
// Top level of the Bezier easing table interpolator.
// Depends on bcti_pkg, bcti_front, bcti_back.
//
// Usage:
//  - A command word is taken when start is high and busy is low. command 0
//    builds the table from the two control values; command 1 looks up a
//    Q16.16 position and interpolates between adjacent entries.
//  - A two-word queue sits between the front and the sequencer, so busy
//    only rises when two words wait behind the one in work.
//  - Each result shows on curve_value/build_done for one cycle with done
//    high. The receiver cannot stall; results are never held.
//  - Lookup: after the pop, done follows six sequencer steps, set by the
//    two table reads and the interpolation multiply-add; the sequencer
//    pops the next word only after it returns to idle.
//  - Build: per entry, a bit-serial divider for i/len, one setup step, nine
//    passes through one shared 32x32 multiplier and one step to the next
//    entry; done rises after the last entry.
//  - The user must write registers through cfg_we/cfg_index/cfg_data only
//    while idle; the block does not enforce it. Reset initialises control
//    state and registers; the table is undefined until the first build.
module bezier_curve_table_interpolator import bcti_pkg::*; #(
	parameter int MAX_TABLE_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [31:0] position,
	output logic        done,
	output logic [31:0] curve_value,
	output logic        build_done,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [18:0] cfg_data
);
	logic signed [18:0] c1_q, c2_q;
	logic [8:0]         len_q;
	cmd_word_t          in_word, head;
	logic               avail, pop;
	logic signed [31:0] value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q  <= '0;
			c2_q  <= 19'sd65536;
			len_q <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CONTROL_ONE:  c1_q  <= cfg_data;
				REG_CONTROL_TWO:  c2_q  <= cfg_data;
				REG_TABLE_LENGTH: len_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	assign in_word.cmd = cmd_t'(command);
	assign in_word.pos = position;

	bcti_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .in_word(in_word),
		.busy(busy), .pop(pop), .avail(avail), .head(head)
	);

	bcti_back #(.MAX_TABLE_ENTRIES(MAX_TABLE_ENTRIES)) u_back (
		.clk(clk), .arst_n(arst_n), .avail(avail), .head(head), .pop(pop),
		.c1(c1_q), .c2(c2_q), .len_reg(len_q),
		.res_valid(done), .res_value(value), .res_build(build_done)
	);

	assign curve_value = value;
endmodule

@@ rtl/bcti_front.sv @@
// Front end: accepts command words into a two-entry queue.
// Depends on bcti_pkg.
module bcti_front import bcti_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  cmd_word_t in_word,
	output logic      busy,
	input  logic      pop,
	output logic      avail,
	output cmd_word_t head
);
	cmd_word_t q_q [2];
	logic [1:0] cnt_q;
	logic       rd_q, wr_q;
	logic       push;

	assign busy  = (cnt_q == 2'd2);
	assign push  = start && !busy;
	assign avail = (cnt_q != 2'd0);
	assign head  = q_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop && avail) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop && avail);
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_q[wr_q] <= in_word;
	end
endmodule

@@ rtl/bcti_back.sv @@
// Back end: table build sequencer with a shared multiplier, and lookup interpolation.
// Depends on bcti_pkg.
module bcti_back import bcti_pkg::*; #(
	parameter int MAX_TABLE_ENTRIES = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               avail,
	input  cmd_word_t          head,
	output logic               pop,
	input  logic signed [18:0] c1,
	input  logic signed [18:0] c2,
	input  logic [8:0]         len_reg,
	output logic               res_valid,
	output logic signed [31:0] res_value,
	output logic               res_build
);
	localparam int AW = $clog2(MAX_TABLE_ENTRIES);
	localparam int LW = $clog2(MAX_TABLE_ENTRIES + 1);

	logic signed [31:0] mem [MAX_TABLE_ENTRIES];

	state_t state_q, state_d;
	logic [LW-1:0] len_q, idx_q;
	logic signed [31:0] t_q, omt_q, tt_q, a_q, b_q;
	logic [5:0]  dcnt_q;
	logic [31:0] rem_q;
	logic [31:0] dsh_q;
	logic [15:0] quo_q;
	logic signed [31:0] vlo_q, vhi_q;
	logic [63:0] s_q;
	logic [7:0]  w_q;
	logic [LW-1:0] lo_q;
	logic         hi_q;
	logic signed [63:0] acc_q;
	logic signed [31:0] ma, mb;
	logic signed [63:0] prod;
	logic signed [31:0] mq;
	logic [LW-1:0] eff_len;
	logic [AW-1:0] li, hi_i, lo_cap;
	logic signed [64:0] fl;

	always_comb begin
		if (len_reg == 9'd0) eff_len = LW'(1);
		else if (32'(len_reg) > MAX_TABLE_ENTRIES) eff_len = LW'(MAX_TABLE_ENTRIES);
		else eff_len = LW'(len_reg);
	end

	assign prod = ma * mb;
	assign mq   = qround(prod);
	assign lo_cap = (lo_q >= len_q - LW'(1)) ? AW'(len_q - LW'(1)) : AW'(lo_q);
	assign li   = lo_cap;
	assign hi_i = (lo_q + LW'(hi_q) >= len_q - LW'(1)) ? AW'(len_q - LW'(1))
		: AW'(lo_q + LW'(hi_q));

	always_comb begin
		ma = t_q;
		mb = t_q;
		unique case (state_q)
			ST_B_M1: begin ma = t_q;     mb = t_q;   end
			ST_B_M2: begin ma = omt_q;   mb = omt_q; end
			ST_B_M3: begin ma = t_q;     mb = a_q;   end
			ST_B_M4: begin ma = 32'(c1); mb = a_q;   end
			ST_B_M5: begin ma = Q_THREE; mb = a_q;   end
			ST_B_M6: begin ma = omt_q;   mb = tt_q;  end
			ST_B_M7: begin ma = 32'(c2); mb = b_q;   end
			ST_B_M8: begin ma = Q_THREE; mb = b_q;   end
			ST_B_SUM: begin ma = t_q;    mb = tt_q;  end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		unique case (state_q)
			ST_IDLE: if (avail) begin
				pop = 1'b1;
				state_d = (head.cmd == CMD_BUILD) ? ST_B_DIV : ST_L_SCALE;
			end
			ST_B_DIV:  if (dcnt_q == 6'd16) state_d = ST_B_OMT;
			ST_B_OMT:  state_d = ST_B_M1;
			ST_B_M1:   state_d = ST_B_M2;
			ST_B_M2:   state_d = ST_B_M3;
			ST_B_M3:   state_d = ST_B_M4;
			ST_B_M4:   state_d = ST_B_M5;
			ST_B_M5:   state_d = ST_B_M6;
			ST_B_M6:   state_d = ST_B_M7;
			ST_B_M7:   state_d = ST_B_M8;
			ST_B_M8:   state_d = ST_B_SUM;
			ST_B_SUM:  state_d = ST_B_NEXT;
			ST_B_NEXT: state_d = (idx_q + LW'(1) == len_q) ? ST_B_DONE : ST_B_DIV;
			ST_B_DONE: state_d = ST_IDLE;
			ST_L_SCALE: state_d = ST_L_RD;
			ST_L_RD:   state_d = ST_L_WAIT;
			ST_L_WAIT: state_d = ST_L_MUL1;
			ST_L_MUL1: state_d = ST_L_MUL2;
			ST_L_MUL2: state_d = ST_L_OUT;
			ST_L_OUT:  state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			res_valid <= 1'b0;
		end else begin
			state_q   <= state_d;
			res_valid <= (state_q == ST_B_DONE) || (state_q == ST_L_OUT);
		end
	end

	assign fl = (acc_q < 0) ? -((-65'(acc_q) + 65'sd255) >>> 8) : 65'(acc_q) >>> 8;

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				len_q <= eff_len;
				idx_q <= '0;
				dcnt_q <= '0;
				rem_q <= '0;
				quo_q <= '0;
				t_q <= head.pos;
			end
			ST_B_DIV: begin
				// restoring divide of (idx*2^17 + len) by 2*len, one quotient bit per cycle
				if (dcnt_q == 6'd0) begin
					quo_q <= '0;
					rem_q <= (32'(idx_q) << 17) + 32'(len_q);
					dsh_q <= 32'(len_q) << 16;
					dcnt_q <= 6'd1;
				end else begin
					if (rem_q >= dsh_q) begin
						rem_q <= rem_q - dsh_q;
						quo_q <= {quo_q[14:0], 1'b1};
					end else begin
						quo_q <= {quo_q[14:0], 1'b0};
					end
					dsh_q <= dsh_q >> 1;
					dcnt_q <= dcnt_q + 6'd1;
				end
			end
			ST_B_OMT: begin
				t_q   <= 32'(quo_q);
				omt_q <= Q_ONE - 32'(quo_q);
			end
			ST_B_M1: tt_q <= mq;
			ST_B_M2: a_q <= mq;
			ST_B_M3: a_q <= mq;
			ST_B_M4: a_q <= mq;
			ST_B_M5: a_q <= mq;
			ST_B_M6: b_q <= mq;
			ST_B_M7: b_q <= mq;
			ST_B_M8: b_q <= sat32(34'(a_q) + 34'(mq));
			ST_B_SUM: mem[AW'(idx_q)] <= sat32(34'(b_q) + 34'(mq));
			ST_B_NEXT: begin
				idx_q <= idx_q + LW'(1);
				dcnt_q <= '0;
			end
			ST_L_SCALE: begin
				if (t_q < 0) s_q <= '0;
				else if (t_q > Q_ONE) s_q <= 64'(len_q) << 16;
				else s_q <= 64'(len_q) * 64'(t_q[16:0]);
			end
			ST_L_RD: begin
				lo_q <= LW'(s_q >> 16);
				hi_q <= (s_q[15:0] != 16'd0);
				w_q  <= s_q[15:8];
			end
			ST_L_WAIT: vlo_q <= mem[li];
			ST_L_MUL1: begin
				vhi_q <= mem[hi_i];
				acc_q <= 64'(vlo_q) * $signed({1'b0, 9'd256 - 9'(w_q)});
			end
			ST_L_MUL2: acc_q <= acc_q + 64'(vhi_q) * $signed({2'b0, w_q});
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_B_DONE) begin
			res_value <= '0;
			res_build <= 1'b1;
		end else if (state_q == ST_L_OUT) begin
			res_build <= 1'b0;
			if (lo_q == len_q) res_value <= Q_ONE;
			else if (!hi_q || w_q <= 8'd1) res_value <= vlo_q;
			else if (w_q >= 8'd254) res_value <= vhi_q;
			else res_value <= fl[31:0];
		end
	end
endmodule
